// ===== sv/sa_pkg.sv =====
// ----------------------------------------------------------------------------
// sa_pkg
// Shared types and constants for the stroke sliding-average filter.
// ----------------------------------------------------------------------------
package sa_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int COORD_BITS_DEF = 20;
    localparam int PRESS_W        = 16;
    localparam int WL_FIELD_W     = 6;

    localparam int APB_DW = 32;
    localparam int APB_AW = 2;

    localparam logic [APB_AW-1:0] REG_WINDOW_LENGTH = 2'd0;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } sa_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } sa_div_ctl_t;

endpackage

// ===== sv/sa_sample_if.sv =====
// ----------------------------------------------------------------------------
// sa_sample_if
// Sample channel: action plus one pen sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sa_sample_if
    #(parameter int COORD_BITS = sa_pkg::COORD_BITS_DEF)
    ();
    import sa_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic [PRESS_W-1:0]           pressure_in;

    modport source (output valid, action, x_in, y_in, pressure_in, input ready);
    modport sink   (input valid, action, x_in, y_in, pressure_in, output ready);

endinterface

// ===== sv/sa_result_if.sv =====
// ----------------------------------------------------------------------------
// sa_result_if
// Result channel: smoothed sample and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sa_result_if
    #(parameter int COORD_BITS = sa_pkg::COORD_BITS_DEF)
    ();
    import sa_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         smooth_valid;
    logic                         first_smooth;
    logic signed [COORD_BITS-1:0] x_avg;
    logic signed [COORD_BITS-1:0] y_avg;
    logic [PRESS_W-1:0]           pressure_avg;

    modport source (output valid, smooth_valid, first_smooth, x_avg, y_avg, pressure_avg,
                    input ready);
    modport sink   (input valid, smooth_valid, first_smooth, x_avg, y_avg, pressure_avg,
                    output ready);

endinterface

// ===== sv/sa_ram.sv =====
// ----------------------------------------------------------------------------
// sa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sa_ram
    #(parameter int WIDTH = 8,
      parameter int DEPTH = 32,
      parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1)
    (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sa_div.sv =====
// ----------------------------------------------------------------------------
// sa_div
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module sa_div
    #(parameter int DW = 26,
      parameter int NW = 7,
      parameter int QW = 20)
    (
    input  logic                clk,
    input  sa_pkg::sa_div_ctl_t ctl,
    input  logic [DW-1:0]       dividend,
    input  logic [NW-1:0]       divisor,
    output logic [QW-1:0]       quotient
    );
    import sa_pkg::*;

    logic [DW-1:0] num_reg, num_next;
    logic [NW-1:0] den_reg, den_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [NW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, num_reg[DW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctl.load)
        begin
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (ctl.step)
        begin
            num_next = {num_reg[DW-2:0], 1'b0};
            rem_next = fits ? NW'(trial - {1'b0, den_reg}) : NW'(trial);
            quo_next = {quo_reg[QW-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

// ===== sv/stroke_sliding_average.sv =====
// ----------------------------------------------------------------------------
// stroke_sliding_average
// Boxcar average of pen samples over a configurable window.
// ----------------------------------------------------------------------------
// Usage: each transaction on the samples channel either adds a pen sample
// (action 0) or clears the stroke (action 1); each yields exactly one
// transaction on the results channel. window_length is written over APB at
// address 0 (value 0 reads as 1, values above MAX_WINDOW saturate); the user
// must write it only while the block is idle (the block does not enforce
// this); writing it clears the stroke.
// A clear, or an add that leaves the window short, goes straight to the
// done state. An add with a full window reads the window ring one entry
// per cycle (one RAM read port) into the sums, then runs three
// bit-serial dividers over a DW-bit dividend (DW = max(COORD_BITS,16) +
// clog2(MAX_WINDOW) + 1, 26 at defaults) before reaching the done state,
// which writes the output register once it is free. One sample is in
// flight at a time; ready returns high in the cycle the result is presented.
// Reset: window_length 1, stroke empty, no result pending. Ring contents
// need no clearing. A stalled receiver holds the output register; the next
// sample is still accepted and parks its result until the slot frees.
// ----------------------------------------------------------------------------
module stroke_sliding_average
    #(parameter int MAX_WINDOW = sa_pkg::MAX_WINDOW_DEF,
      parameter int COORD_BITS = sa_pkg::COORD_BITS_DEF)
    (
    input  logic                      clk,
    input  logic                      rst_n,
    sa_sample_if.sink                 samples,
    sa_result_if.source               results,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sa_pkg::APB_AW-1:0] paddr,
    input  logic [sa_pkg::APB_DW-1:0] pwdata,
    output logic [sa_pkg::APB_DW-1:0] prdata,
    output logic                      pready
    );
    import sa_pkg::*;

    localparam int LW  = $clog2(MAX_WINDOW);
    localparam int PW  = (LW > 0) ? LW : 1;
    localparam int WLW = $clog2(MAX_WINDOW + 1);
    localparam int CW  = (WLW > WL_FIELD_W) ? WLW : WL_FIELD_W;
    localparam int SW  = COORD_BITS + LW;
    localparam int SPW = PRESS_W + LW;
    localparam int VW  = (COORD_BITS > PRESS_W) ? COORD_BITS : PRESS_W;
    localparam int DW  = VW + LW + 1;
    localparam int NW  = LW + 2;
    localparam int RW  = 2 * COORD_BITS + PRESS_W;
    localparam int SCW = $clog2(DW + 1);

    localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

    sa_state_t state_reg, state_next;

    logic [WLW-1:0]        wl_reg, wl_next;
    logic [PW-1:0]         wp_reg, wp_next;
    logic [WLW-1:0]        fill_reg, fill_next;
    logic [WLW-1:0]        idx_reg, idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [SW-1:0]         acc_x_reg, acc_x_next;
    logic [SW-1:0]         acc_y_reg, acc_y_next;
    logic [SPW-1:0]        acc_p_reg, acc_p_next;
    logic [SCW-1:0]        step_reg, step_next;
    logic                  first_reg, first_next;
    logic                  zero_reg, zero_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  osmooth_reg, osmooth_next;
    logic                  ofirst_reg, ofirst_next;
    logic [COORD_BITS-1:0] ox_reg, ox_next;
    logic [COORD_BITS-1:0] oy_reg, oy_next;
    logic [PRESS_W-1:0]    op_reg, op_next;

    logic                  accept;
    logic                  cfg_wr;
    logic [CW-1:0]         cfg_val;
    logic [WLW-1:0]        cfg_wl;
    logic                  wp_wrap;
    logic [PW-1:0]         wp_new;
    logic [WLW-1:0]        fill_new;
    logic                  was_full;
    logic                  now_full;
    logic                  sum_done;
    logic                  out_free;
    logic                  ram_we;
    logic [RW-1:0]         ram_wdata;
    logic [RW-1:0]         ram_rdata;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [PRESS_W-1:0]    rd_p;
    sa_div_ctl_t           div_ctl;
    logic [DW-1:0]         dvd_x;
    logic [DW-1:0]         dvd_y;
    logic [DW-1:0]         dvd_p;
    logic [NW-1:0]         dvs;
    logic [COORD_BITS-1:0] quo_x;
    logic [COORD_BITS-1:0] quo_y;
    logic [PRESS_W-1:0]    quo_p;

    // APB
    assign pready  = 1'b1;
    assign prdata  = APB_DW'(wl_reg);
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr == REG_WINDOW_LENGTH);
    assign cfg_val = CW'(pwdata[WL_FIELD_W-1:0]);

    always_comb
    begin
        if (cfg_val == '0)
        begin
            cfg_wl = WLW'(1);
        end
        else if (cfg_val > CW'(MAX_WINDOW))
        begin
            cfg_wl = WLW'(MAX_WINDOW);
        end
        else
        begin
            cfg_wl = WLW'(cfg_val);
        end
    end

    // ring bookkeeping for an add
    assign accept   = samples.valid && samples.ready;
    assign wp_wrap  = (wp_reg == '0) || (WLW'(wp_reg) >= wl_reg);
    assign wp_new   = wp_wrap ? PW'(wl_reg - WLW'(1)) : (wp_reg - PW'(1));
    assign fill_new = (fill_reg < wl_reg) ? (fill_reg + WLW'(1)) : fill_reg;
    assign was_full = (fill_reg == wl_reg);
    assign now_full = (fill_new == wl_reg);
    assign sum_done = (idx_reg == wl_reg) && !rd_vld_reg;
    assign out_free = !ovalid_reg || results.ready;

    // coordinates stored offset-binary so all sums are unsigned
    assign ram_we    = accept && (samples.action == ACT_ADD);
    assign ram_wdata = {samples.x_in ^ SIGN_BIT, samples.y_in ^ SIGN_BIT,
                        samples.pressure_in};

    sa_ram #(.WIDTH(RW), .DEPTH(MAX_WINDOW), .AW(PW)) u_ring
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_new),
        .wdata (ram_wdata),
        .raddr (idx_reg[PW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[RW-1 -: COORD_BITS];
    assign rd_y = ram_rdata[PRESS_W +: COORD_BITS];
    assign rd_p = ram_rdata[PRESS_W-1:0];

    // rounded mean = floor((2*sum + n) / (2*n))
    assign dvd_x = (DW'(acc_x_reg) << 1) + DW'(wl_reg);
    assign dvd_y = (DW'(acc_y_reg) << 1) + DW'(wl_reg);
    assign dvd_p = (DW'(acc_p_reg) << 1) + DW'(wl_reg);
    assign dvs   = NW'({wl_reg, 1'b0});

    sa_div #(.DW(DW), .NW(NW), .QW(COORD_BITS)) u_div_x
    (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (dvd_x),
        .divisor  (dvs),
        .quotient (quo_x)
    );

    sa_div #(.DW(DW), .NW(NW), .QW(COORD_BITS)) u_div_y
    (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (dvd_y),
        .divisor  (dvs),
        .quotient (quo_y)
    );

    sa_div #(.DW(DW), .NW(NW), .QW(PRESS_W)) u_div_p
    (
        .clk      (clk),
        .ctl      (div_ctl),
        .dividend (dvd_p),
        .divisor  (dvs),
        .quotient (quo_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((samples.action == ACT_CLEAR) || !now_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == SCW'(DW - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        samples.ready = (state_reg == ST_IDLE);
        div_ctl.load  = (state_reg == ST_SUM) && sum_done;
        div_ctl.step  = (state_reg == ST_DIV);

        wl_next      = wl_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        rd_vld_next  = 1'b0;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        acc_p_next   = acc_p_reg;
        step_next    = step_reg;
        first_next   = first_reg;
        zero_next    = zero_reg;
        ovalid_next  = ovalid_reg;
        osmooth_next = osmooth_reg;
        ofirst_next  = ofirst_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        op_next      = op_reg;

        if (ovalid_reg && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    acc_p_next = '0;
                    if (samples.action == ACT_CLEAR)
                    begin
                        wp_next   = '0;
                        fill_next = '0;
                        zero_next = 1'b1;
                    end
                    else
                    begin
                        wp_next    = wp_new;
                        fill_next  = fill_new;
                        first_next = !was_full;
                        zero_next  = !now_full;
                    end
                end
            end
            ST_SUM:
            begin
                if (idx_reg < wl_reg)
                begin
                    idx_next    = idx_reg + WLW'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    acc_x_next = acc_x_reg + SW'(rd_x);
                    acc_y_next = acc_y_reg + SW'(rd_y);
                    acc_p_next = acc_p_reg + SPW'(rd_p);
                end
                step_next = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + SCW'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (zero_reg)
                    begin
                        osmooth_next = 1'b0;
                        ofirst_next  = 1'b0;
                        ox_next      = '0;
                        oy_next      = '0;
                        op_next      = '0;
                    end
                    else
                    begin
                        osmooth_next = 1'b1;
                        ofirst_next  = first_reg;
                        ox_next      = quo_x ^ SIGN_BIT;
                        oy_next      = quo_y ^ SIGN_BIT;
                        op_next      = quo_p;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_wr)
        begin
            wl_next   = cfg_wl;
            wp_next   = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wl_reg     <= WLW'(1);
            wp_reg     <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wl_reg     <= wl_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        acc_p_reg   <= acc_p_next;
        first_reg   <= first_next;
        zero_reg    <= zero_next;
        osmooth_reg <= osmooth_next;
        ofirst_reg  <= ofirst_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        op_reg      <= op_next;
    end

    assign results.valid        = ovalid_reg;
    assign results.smooth_valid = osmooth_reg;
    assign results.first_smooth = ofirst_reg;
    assign results.x_avg        = ox_reg;
    assign results.y_avg        = oy_reg;
    assign results.pressure_avg = op_reg;

endmodule

// ===== sv/sa_checker.sv =====
// ----------------------------------------------------------------------------
// sa_checker
// Port-level assertions for stroke_sliding_average, bound to the top level.
// ----------------------------------------------------------------------------
module sa_checker
    #(parameter int COORD_BITS = sa_pkg::COORD_BITS_DEF)
    (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      smooth_valid,
    input logic                      first_smooth,
    input logic [COORD_BITS-1:0]     x_avg,
    input logic [COORD_BITS-1:0]     y_avg,
    input logic [sa_pkg::PRESS_W-1:0] pressure_avg
    );
    import sa_pkg::*;

    // one sample in flight at a time
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while another is in flight");

    // no smoothing means an all-zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !smooth_valid |-> !first_smooth && (x_avg == '0) &&
        (y_avg == '0) && (pressure_avg == '0))
        else $error("non-smoothed result carries data");

    a_first_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_smooth |-> smooth_valid)
        else $error("first_smooth without smooth_valid");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no transaction in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_avg) && $stable(y_avg) &&
        $stable(pressure_avg) && $stable(smooth_valid) && $stable(first_smooth))
        else $error("stalled result changed");

endmodule

bind stroke_sliding_average sa_checker #(.COORD_BITS(COORD_BITS)) u_sa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .smooth_valid (results.smooth_valid),
    .first_smooth (results.first_smooth),
    .x_avg        (results.x_avg),
    .y_avg        (results.y_avg),
    .pressure_avg (results.pressure_avg)
);
